// ----- rtl/agd_pkg.sv -----
// Package for the audio gain / TPDF dither block: widths, constants and shared types.
package agd_pkg;

   // field widths
   localparam int SampleW = 24;
   localparam int GainW   = 17;
   localparam int SeedW   = 32;

   // shared multiplier operand and product widths
   localparam int MulAW = 33;
   localparam int MulBW = 22;
   localparam int MulPW = MulAW + MulBW;

   // scaled product, Q1.23 with headroom for gain up to 4.0 and dither
   localparam int ScaledW = 27;

   // configuration register indexes
   localparam logic CSR_GAIN   = 1'b0;
   localparam logic CSR_OUT_EN = 1'b1;

   // register reset values and limits
   localparam logic [GainW-1:0] GAIN_RESET = 17'd16384;
   localparam logic [GainW-1:0] GAIN_MAX   = 17'd65536;

   // linear congruential generator
   localparam logic [SeedW-1:0] LCG_MUL    = 32'd1664525;
   localparam logic [SeedW-1:0] LCG_ADD    = 32'd1013904223;
   localparam logic [SeedW-1:0] SEED_RESET = 32'h0123_4567;

   // rounding bias for the Q2.14 gain shift, dither offset and output limits
   localparam logic signed [MulPW-1:0]   ROUND_BIAS = 55'sd8192;
   localparam logic signed [ScaledW-1:0] DITHER_OFS = 27'sd256;
   localparam logic signed [ScaledW-1:0] Q23_MAX    = 27'sd8388607;
   localparam logic signed [ScaledW-1:0] Q23_MIN    = -27'sd8388608;

   // request to the shared multiplier
   typedef struct packed {
      logic                    en;
      logic signed [MulAW-1:0] a;
      logic signed [MulBW-1:0] b;
   } agd_mul_req_type;

endpackage

// ----- rtl/agd_if.sv -----
// Stream interfaces for the sample request and response channels.
interface agd_req_if;
   logic                       valid;
   logic                       ready;
   logic signed [23:0]         sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface agd_rsp_if;
   logic                       valid;
   logic                       ready;
   logic signed [23:0]         sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// ----- rtl/agd_mul.sv -----
// Shared signed multiplier with a registered product.
module agd_mul (
   input  logic                                clock,
   input  agd_pkg::agd_mul_req_type            mul_req,
   output logic signed [agd_pkg::MulPW-1:0]    prod_ff
);
   import agd_pkg::*;

   logic signed [MulPW-1:0] prod_in;

   // full signed product of the two operands
   assign prod_in = MulPW'(mul_req.a) * MulPW'(mul_req.b);

   // product holds until the next enabled operation
   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ----- rtl/agd_core.sv -----
// Sequencer and datapath: gain scaling, dither generator, saturation and output register.
module agd_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [agd_pkg::GainW-1:0]         gain,
   input  logic                              out_en,
   agd_req_if.sink                           req,
   agd_rsp_if.source                         rsp,
   output agd_pkg::agd_mul_req_type          mul_req,
   input  logic signed [agd_pkg::MulPW-1:0]  prod
);
   import agd_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LCG1 = 2'd1;
   localparam logic [1:0] S_LCG2 = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]                state_ff, state_in;
   logic [SeedW-1:0]          seed_ff, seed_in;
   logic                      mute_ff, mute_in;
   logic signed [ScaledW-1:0] scaled_ff, scaled_in;
   logic [22:0]               u1_ff, u1_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [SampleW-1:0] rsp_data_ff, rsp_data_in;

   logic                      accept;
   logic                      out_free;
   logic [GainW-1:0]          gain_sat;
   logic [SeedW-1:0]          seed_step;
   logic signed [MulPW-1:0]   prod_rnd;
   logic [23:0]               u_sum;
   logic signed [ScaledW-1:0] mix;
   logic signed [SampleW-1:0] mix_sat;

   assign req.ready      = (state_ff == S_IDLE);
   assign accept         = req.valid && req.ready;
   assign out_free       = !rsp_valid_ff || rsp.ready;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.sample_out = rsp_data_ff;

   // gain is limited to 4.0
   assign gain_sat = (gain > GAIN_MAX) ? GAIN_MAX : gain;

   // one generator step from the multiplier's low word
   assign seed_step = prod[SeedW-1:0] + LCG_ADD;

   // round half up from Q3.37 to Q1.23
   assign prod_rnd = prod + ROUND_BIAS;

   // triangular dither added to the scaled sample, then clipped
   assign u_sum = {1'b0, u1_ff} + {1'b0, seed_step[31:9]};
   assign mix   = scaled_ff + ScaledW'(u_sum[23:15]) - DITHER_OFS;

   always_comb begin
      if (mix > Q23_MAX) begin
         mix_sat = SampleW'(Q23_MAX);
      end else if (mix < Q23_MIN) begin
         mix_sat = SampleW'(Q23_MIN);
      end else begin
         mix_sat = mix[SampleW-1:0];
      end
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_req.en = 1'b0;
      mul_req.a  = '0;
      mul_req.b  = '0;
      unique case (state_ff)
         S_IDLE: begin
            mul_req.en = accept && out_en;
            mul_req.a  = MulAW'(req.sample_in);
            mul_req.b  = MulBW'(gain_sat);
         end
         S_LCG1: begin
            mul_req.en = 1'b1;
            mul_req.a  = MulAW'(seed_ff);
            mul_req.b  = MulBW'(LCG_MUL);
         end
         S_LCG2: begin
            mul_req.en = 1'b1;
            mul_req.a  = MulAW'(seed_step);
            mul_req.b  = MulBW'(LCG_MUL);
         end
         S_FIN: begin
            mul_req.en = 1'b0;
         end
         default: begin
            mul_req.en = 1'b0;
         end
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      mute_in      = mute_ff;
      scaled_in    = scaled_ff;
      u1_in        = u1_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mute_in  = !out_en;
               state_in = out_en ? S_LCG1 : S_FIN;
            end
         end
         S_LCG1: begin
            scaled_in = prod_rnd[ScaledW+13:14];
            state_in  = S_LCG2;
         end
         S_LCG2: begin
            seed_in  = seed_step;
            u1_in    = seed_step[31:9];
            state_in = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (mute_ff) begin
                  rsp_data_in = '0;
               end else begin
                  rsp_data_in = mix_sat;
                  seed_in     = seed_step;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         seed_ff      <= SEED_RESET;
         mute_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         mute_ff      <= mute_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      scaled_ff   <= scaled_in;
      u1_ff       <= u1_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- rtl/audio_gain_tpdf_dither_top.sv -----
// Top level of the audio gain stage with TPDF dither and clipping.
//
// Usage: one signed Q1.23 sample is taken on the req channel per beat and one
// signed Q1.23 sample leaves on the rsp channel per beat, in order. The sample
// is scaled by the gain register (unsigned Q2.14, clamped at 4.0), rounded,
// summed with triangular dither from a 32-bit LCG and clipped to full scale.
// Registers are to be written through csr_we / csr_index / csr_wdata only
// while idle, which the block does not enforce: index 0 is gain, index 1 is
// output enable. With output disabled each beat returns zero and the dither
// generator holds. An item passes through accept, two generator steps and
// finish; one 33x22 multiplier is shared by the gain product and both
// generator steps, so a new item is accepted only once the last has finished.
// The result register loads in the finish state. A muted item skips the
// generator steps. If rsp stalls, the finished item waits in the sequencer
// and req stays low-ready until the output register frees up.
// Reset (synchronous, active high) sets gain to unity, disables output,
// reloads the dither seed and empties the output register.
module audio_gain_tpdf_dither_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic                            csr_index,
   input  logic [agd_pkg::GainW-1:0]       csr_wdata,
   agd_req_if.sink                         req,
   agd_rsp_if.source                       rsp
);
   import agd_pkg::*;

   logic [GainW-1:0]        gain_ff;
   logic                    out_en_ff;
   agd_mul_req_type         mul_req;
   logic signed [MulPW-1:0] prod;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         out_en_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_GAIN:   gain_ff   <= csr_wdata;
            CSR_OUT_EN: out_en_ff <= csr_wdata[0];
            default:    gain_ff   <= gain_ff;
         endcase
      end
   end

   agd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .gain    (gain_ff),
      .out_en  (out_en_ff),
      .req     (req),
      .rsp     (rsp),
      .mul_req (mul_req),
      .prod    (prod)
   );

   agd_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod_ff (prod)
   );

endmodule

// ----- tb/tb_audio_gain_tpdf_dither_top.sv -----
// Testbench for the audio gain / TPDF dither block: predicts every output sample and checks it.
`timescale 1ns / 100ps

// Tracks gain, output enable and dither seed, predicts output samples and checks them in order.
class dither_sample_tracker;
   localparam logic [31:0] SeedMul   = 32'd1664525;
   localparam logic [31:0] SeedInc   = 32'd1013904223;
   localparam logic [31:0] SeedStart = 32'h0123_4567;
   localparam logic [16:0] GainCeil  = 17'd65536;
   localparam longint      FullPos   = 64'sd8388607;
   localparam longint      FullNeg   = -64'sd8388608;
   localparam int          RingDepth = 64;

   logic [16:0]        gain;
   bit                 play;
   logic [31:0]        seed;
   logic signed [23:0] expected_ring[RingDepth];
   int                 ring_head;
   int                 ring_count;
   int                 errors;
   int                 mismatches;

   function new();
      gain       = 17'd16384;
      play       = 1'b0;
      seed       = SeedStart;
      ring_head  = 0;
      ring_count = 0;
      errors     = 0;
      mismatches = 0;
   endfunction

   function void write_reg(logic idx, logic [16:0] value);
      if (idx == agd_pkg::CSR_GAIN) begin
         gain = value;
      end else begin
         play = value[0];
      end
   endfunction

   // one LCG step, top 23 bits
   function logic [22:0] next_dither_word();
      seed = seed * SeedMul + SeedInc;
      return seed[31:9];
   endfunction

   // gain, round half up, add triangular dither, clip to Q1.23
   function logic signed [23:0] gained_sample(logic signed [23:0] s);
      logic [16:0] g;
      logic [22:0] u1;
      logic [22:0] u2;
      logic [23:0] usum;
      longint      level;
      if (!play) begin
         return '0;
      end
      g     = (gain > GainCeil) ? GainCeil : gain;
      level = longint'(s) * longint'({15'd0, g});
      level = (level + 64'sd8192) >>> 14;
      u1    = next_dither_word();
      u2    = next_dither_word();
      usum  = u1 + u2;
      level = level + longint'(usum >> 15) - 64'sd256;
      if (level > FullPos) level = FullPos;
      if (level < FullNeg) level = FullNeg;
      return level[23:0];
   endfunction

   // expected samples wait in a small ring, oldest at the head
   function void note_sample_in(logic signed [23:0] s);
      int slot;
      if (ring_count == RingDepth) begin
         errors++;
         return;
      end
      slot = (ring_head + ring_count) % RingDepth;
      expected_ring[slot] = gained_sample(s);
      ring_count++;
   endfunction

   function void check_sample_out(logic signed [23:0] got);
      logic signed [23:0] want;
      if (ring_count == 0) begin
         errors++;
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: output sample %0d with none expected", $time, got);
         return;
      end
      want       = expected_ring[ring_head];
      ring_head  = (ring_head + 1) % RingDepth;
      ring_count--;
      if (got !== want) begin
         errors++;
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: sample_out mismatch: expected %0d, got %0d", $time, want, got);
      end
   endfunction

   function int pending();
      return ring_count;
   endfunction
endclass

module tb_audio_gain_tpdf_dither_top;
   import agd_pkg::*;

   localparam int CycleLimit   = 400000;
   localparam int PhaseCount   = 12;
   localparam int PhaseSamples = 125;

   logic             clock;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [GainW-1:0] csr_wdata;
   bit               req_steady;
   bit               rsp_steady;
   int               cycle_count;

   agd_req_if req_bus ();
   agd_rsp_if rsp_bus ();

   dither_sample_tracker tracker;

   audio_gain_tpdf_dither_top DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req       (req_bus),
      .rsp       (rsp_bus)
   );

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // wait per beat, with occasional stretches of back-to-back traffic
   function automatic int draw_wait(ref bit steady);
      if ($urandom_range(0, 31) == 0) steady = !steady;
      return steady ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic logic signed [23:0] draw_sample();
      case ($urandom_range(0, 5))
         3:       return 24'sd8388607 - 24'($urandom_range(0, 4095));
         4:       return -24'sd8388608 + 24'($urandom_range(0, 4095));
         5:       return 24'($urandom_range(0, 8192)) - 24'sd4096;
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [GainW-1:0] draw_gain();
      case ($urandom_range(0, 7))
         0:       return 17'd0;
         1:       return 17'd65536;
         2:       return 17'd131071;
         3:       return 17'd16384;
         4:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   // one register write; the port is then left idle before the task returns
   task automatic write_reg(input logic idx, input logic [GainW-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.write_reg(idx, value);
      csr_we    <= 1'b0;
      @(posedge clock);
   endtask

   // send one sample; valid stays high after the beat unless the next one waits
   task automatic send_sample(input logic signed [23:0] s);
      int gap;
      gap = draw_wait(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.sample_in <= s;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      tracker.note_sample_in(s);
   endtask

   // let every expected sample come back, then settle before touching registers
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [GainW-1:0] g, input bit play);
      drain();
      write_reg(CSR_GAIN, g);
      write_reg(CSR_OUT_EN, {16'd0, play});
   endtask

   // result side: random stalls, one check per beat
   task automatic collect_samples();
      int gap;
      forever begin
         gap = draw_wait(rsp_steady);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         tracker.check_sample_out(rsp_bus.sample_out);
      end
   endtask

   initial begin
      tracker           = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= CSR_GAIN;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      rsp_bus.ready     <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         collect_samples();
      join_none

      // after reset: output disabled, samples come back as silence
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sd0);

      // unity gain
      apply_settings(17'd16384, 1'b1);
      send_sample(24'sd0);
      send_sample(24'sd1);
      send_sample(-24'sd1);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sh555555);
      send_sample(24'shAAAAAA);

      // gain 4.0, positive and negative clipping
      apply_settings(17'd65536, 1'b1);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sd3000000);
      send_sample(-24'sd3000000);

      // register above four acts as four
      apply_settings(17'd131071, 1'b1);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sd1);

      // zero gain leaves dither only
      apply_settings(17'd0, 1'b1);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);

      // smallest gain, rounding at exact halves
      apply_settings(17'd1, 1'b1);
      send_sample(24'sd8192);
      send_sample(-24'sd8192);
      send_sample(24'sd24576);

      // muted again: zero out, generator holds
      apply_settings(17'd1, 1'b0);
      send_sample(24'sd8388607);
      send_sample(24'sd12345);

      // random phases over gain and enable settings
      for (int p = 0; p < PhaseCount; p++) begin
         apply_settings(draw_gain(), $urandom_range(0, 5) != 0);
         for (int i = 0; i < PhaseSamples; i++) begin
            send_sample(draw_sample());
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (tracker.pending() != 0) tracker.errors++;
      if (tracker.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
